// ----- design/spa_pkg.sv -----
// ----------------------------------------------------------------------------
// spa_pkg: shared types and constants for the sparse polynomial adder
// Beat payloads, term record, table command and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package spa_pkg;

    localparam int MAX_TERMS_DEF = 16;

    typedef enum logic [1:0] {
        KIND_INS_A = 2'd0,
        KIND_INS_B = 2'd1,
        KIND_ADD   = 2'd2,
        KIND_CLEAR = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_FULL = 2'd1,
        STAT_SUM  = 2'd2,
        STAT_NONE = 2'd3
    } status_t;

    typedef struct packed {
        kind_t              kind;
        logic signed [31:0] coefficient;
        logic signed [15:0] exponent;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic signed [31:0] sum_coefficient;
        logic signed [15:0] sum_exponent;
        logic               last;
    } rsp_t;

    typedef struct packed {
        logic signed [31:0] coefficient;
        logic signed [15:0] exponent;
    } term_t;

    typedef enum logic [1:0] {
        TOP_NONE   = 2'd0,
        TOP_INSERT = 2'd1,
        TOP_POP    = 2'd2,
        TOP_CLEAR  = 2'd3
    } tbl_op_t;

    typedef struct packed {
        tbl_op_t op;
        term_t   term;
    } tbl_cmd_t;

endpackage : spa_pkg

`default_nettype wire

// ----- design/spa_cell.sv -----
// ----------------------------------------------------------------------------
// spa_cell: one term slot of a sorted term chain
// Holds a term; shifts right on sorted insert, left (head wraps to tail) on pop.
// ----------------------------------------------------------------------------
`default_nettype none

module spa_cell (
    input  wire logic             clk,
    input  spa_pkg::tbl_cmd_t     cmd,
    input  wire logic             valid,
    input  wire logic             tail,
    input  wire logic             prev_ge,
    input  spa_pkg::term_t        prev_term,
    input  spa_pkg::term_t        next_term,
    input  spa_pkg::term_t        head_term,
    output logic                  ge,
    output spa_pkg::term_t        term
);
    import spa_pkg::*;

    term_t term_reg;
    term_t term_next;

    // this slot stays put on insert when its exponent is not below the new one
    assign ge   = valid && (term_reg.exponent >= cmd.term.exponent);
    assign term = term_reg;

    always_comb
    begin
        term_next = term_reg;
        unique case (cmd.op)
            TOP_INSERT:
            begin
                if (!ge)
                begin
                    term_next = prev_ge ? cmd.term : prev_term;
                end
            end
            TOP_POP:
            begin
                term_next = tail ? head_term : next_term;
            end
            TOP_NONE, TOP_CLEAR:
            begin
                term_next = term_reg;
            end
            default:
            begin
                term_next = term_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        term_reg <= term_next;
    end

endmodule : spa_cell

`default_nettype wire

// ----- design/spa_table.sv -----
// ----------------------------------------------------------------------------
// spa_table: one sorted term table built as a chain of cells
// Sorted insert, pop-and-rotate of the head, clear by count.
// ----------------------------------------------------------------------------
`default_nettype none

module spa_table #(
    parameter int MAX_TERMS = spa_pkg::MAX_TERMS_DEF,
    localparam int CW = $clog2(MAX_TERMS + 1)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  spa_pkg::tbl_cmd_t     cmd,
    output logic [CW-1:0]         count,
    output spa_pkg::term_t        head
);
    import spa_pkg::*;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          full;
    tbl_cmd_t      cell_cmd;
    term_t         terms [MAX_TERMS];
    logic          ges   [MAX_TERMS];

    assign full  = (count_reg == CW'(MAX_TERMS));
    assign count = count_reg;
    assign head  = terms[0];

    // a full table drops the insert
    always_comb
    begin
        cell_cmd = cmd;
        if (cmd.op == TOP_INSERT && full)
        begin
            cell_cmd.op = TOP_NONE;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        unique case (cell_cmd.op)
            TOP_INSERT: count_next = count_reg + CW'(1);
            TOP_CLEAR:  count_next = '0;
            TOP_NONE, TOP_POP: count_next = count_reg;
            default:    count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    for (genvar i = 0; i < MAX_TERMS; i++)
    begin : g_cell
        logic  prev_ge;
        term_t prev_term;
        term_t next_term;

        if (i == 0)
        begin : g_first
            assign prev_ge   = 1'b0;
            assign prev_term = cell_cmd.term;
        end
        else
        begin : g_mid
            assign prev_ge   = ges[i-1];
            assign prev_term = terms[i-1];
        end

        if (i == MAX_TERMS - 1)
        begin : g_end
            assign next_term = terms[0];
        end
        else
        begin : g_inner
            assign next_term = terms[i+1];
        end

        spa_cell u_cell (
            .clk       (clk),
            .cmd       (cell_cmd),
            .valid     (count_reg > CW'(i)),
            .tail      (count_reg == CW'(i + 1)),
            .prev_ge   (prev_ge),
            .prev_term (prev_term),
            .next_term (next_term),
            .head_term (terms[0]),
            .ge        (ges[i]),
            .term      (terms[i])
        );
    end

endmodule : spa_table

`default_nettype wire

// ----- design/sparse_polynomial_add.sv -----
// Insert, clear and empty add give their single beat, registered, in the cycle after acceptance.
// An add with terms moves to the merge state, which registers one beat per cycle unless the
// result side stalls, na+nb at most. Inserts and clears are taken while the result side is free;
// an add holds the request side until its last beat, as each merge step pops one or both heads.
// Reset: rst_n clears both table counts and the control state; term cells are not reset.
// ----------------------------------------------------------------------------
// sparse_polynomial_add: two sorted term tables and their merge
// Keeps tables A and B as cell chains and streams the saturated sum on add.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_polynomial_add #(
    parameter int MAX_TERMS = spa_pkg::MAX_TERMS_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         req_valid,
    output logic              req_ready,
    input  spa_pkg::req_t     req,
    output logic              rsp_valid,
    input  wire logic         rsp_ready,
    output spa_pkg::rsp_t     rsp
);
    import spa_pkg::*;

    localparam int CW = $clog2(MAX_TERMS + 1);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_MERGE = 2'b10
    } state_t;

    state_t        state_reg,  state_next;
    logic [CW-1:0] rem_a_reg,  rem_a_next;
    logic [CW-1:0] rem_b_reg,  rem_b_next;
    logic          valid_reg,  valid_next;
    rsp_t          rsp_reg,    rsp_next;

    tbl_cmd_t      cmd_a, cmd_b;
    logic [CW-1:0] count_a, count_b;
    term_t         head_a, head_b;

    logic          out_free;
    logic          accept;
    logic          take_a, take_b;
    logic [32:0]   wide_sum;
    logic [31:0]   sat_sum;
    logic [CW-1:0] left_a, left_b;

    spa_table #(.MAX_TERMS(MAX_TERMS)) u_table_a (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_a),
        .count (count_a),
        .head  (head_a)
    );

    spa_table #(.MAX_TERMS(MAX_TERMS)) u_table_b (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_b),
        .count (count_b),
        .head  (head_b)
    );

    assign out_free  = !valid_reg || rsp_ready;
    assign req_ready = (state_reg == ST_IDLE) && out_free;
    assign accept    = req_valid && req_ready;
    assign rsp_valid = valid_reg;
    assign rsp       = rsp_reg;

    // merge pick on the two heads
    always_comb
    begin
        take_a = 1'b0;
        take_b = 1'b0;
        if (rem_a_reg != '0 && rem_b_reg != '0 && head_a.exponent == head_b.exponent)
        begin
            take_a = 1'b1;
            take_b = 1'b1;
        end
        else if (rem_b_reg == '0 ||
                 (rem_a_reg != '0 && head_a.exponent > head_b.exponent))
        begin
            take_a = 1'b1;
        end
        else
        begin
            take_b = 1'b1;
        end
    end

    assign wide_sum = {head_a.coefficient[31], head_a.coefficient}
                    + {head_b.coefficient[31], head_b.coefficient};

    always_comb
    begin
        if (wide_sum[32] != wide_sum[31])
        begin
            sat_sum = wide_sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        else
        begin
            sat_sum = wide_sum[31:0];
        end
    end

    assign left_a = rem_a_reg - CW'(take_a);
    assign left_b = rem_b_reg - CW'(take_b);

    always_comb
    begin
        state_next = state_reg;
        rem_a_next = rem_a_reg;
        rem_b_next = rem_b_reg;
        valid_next = valid_reg && !rsp_ready;
        rsp_next   = rsp_reg;
        cmd_a.op   = TOP_NONE;
        cmd_a.term = '{coefficient: req.coefficient, exponent: req.exponent};
        cmd_b      = cmd_a;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    valid_next = 1'b1;
                    rsp_next   = '{status: STAT_OK, sum_coefficient: '0,
                                   sum_exponent: '0, last: 1'b1};
                    unique case (req.kind)
                        KIND_INS_A:
                        begin
                            cmd_a.op = TOP_INSERT;
                            if (count_a == CW'(MAX_TERMS))
                            begin
                                rsp_next.status = STAT_FULL;
                            end
                        end
                        KIND_INS_B:
                        begin
                            cmd_b.op = TOP_INSERT;
                            if (count_b == CW'(MAX_TERMS))
                            begin
                                rsp_next.status = STAT_FULL;
                            end
                        end
                        KIND_CLEAR:
                        begin
                            cmd_a.op = TOP_CLEAR;
                            cmd_b.op = TOP_CLEAR;
                        end
                        KIND_ADD:
                        begin
                            if (count_a == '0 && count_b == '0)
                            begin
                                rsp_next.status = STAT_NONE;
                            end
                            else
                            begin
                                // first merged beat comes from the merge state
                                valid_next = 1'b0;
                                rem_a_next = count_a;
                                rem_b_next = count_b;
                                state_next = ST_MERGE;
                            end
                        end
                        default:
                        begin
                            rsp_next.status = STAT_OK;
                        end
                    endcase
                end
            end
            ST_MERGE:
            begin
                if (out_free)
                begin
                    valid_next = 1'b1;
                    rsp_next.status = STAT_SUM;
                    if (take_a && take_b)
                    begin
                        rsp_next.sum_coefficient = sat_sum;
                    end
                    else if (take_a)
                    begin
                        rsp_next.sum_coefficient = head_a.coefficient;
                    end
                    else
                    begin
                        rsp_next.sum_coefficient = head_b.coefficient;
                    end
                    rsp_next.sum_exponent = take_a ? head_a.exponent : head_b.exponent;
                    rsp_next.last = (left_a == '0) && (left_b == '0);
                    if (take_a)
                    begin
                        cmd_a.op = TOP_POP;
                    end
                    if (take_b)
                    begin
                        cmd_b.op = TOP_POP;
                    end
                    rem_a_next = left_a;
                    rem_b_next = left_b;
                    if (rsp_next.last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
            rem_a_reg <= '0;
            rem_b_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            rem_a_reg <= rem_a_next;
            rem_b_reg <= rem_b_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

endmodule : sparse_polynomial_add

`default_nettype wire

// ----- design/spa_checker.sv -----
// ----------------------------------------------------------------------------
// spa_checker: port-level checks for the sparse polynomial adder
// Watches both channels and the shape of the result stream.
// ----------------------------------------------------------------------------
`default_nettype none

module spa_checker (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         req_valid,
    input  wire logic         req_ready,
    input  spa_pkg::req_t     req,
    input  wire logic         rsp_valid,
    input  wire logic         rsp_ready,
    input  spa_pkg::rsp_t     rsp
);
    import spa_pkg::*;

    // a stalled result beat holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result beat changed while stalled");

    // insert and clear answer with one final beat on the next cycle
    a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req.kind != KIND_ADD |=>
            rsp_valid && rsp.last && (rsp.status == STAT_OK || rsp.status == STAT_FULL))
        else $error("insert or clear did not answer with one final beat");

    // no new request while a merge stream is still going
    a_no_req_mid_stream: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.last |-> !req_ready)
        else $error("request taken in the middle of a merge stream");

    // non-sum beats are single, final and carry no term
    a_plain_beat: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != STAT_SUM |->
            rsp.last && rsp.sum_coefficient == 32'sd0 && rsp.sum_exponent == 16'sd0)
        else $error("status beat malformed");

endmodule : spa_checker

bind sparse_polynomial_add spa_checker u_spa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

`default_nettype wire
